[rtl/bounded_vector_insert_remove_core_assert.svh]
// Assertion macros for the bounded vector insert/remove core.
`ifndef BOUNDED_VECTOR_INSERT_REMOVE_CORE_ASSERT_SVH
`define BOUNDED_VECTOR_INSERT_REMOVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BVIR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BVIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BVIR_ASSERT_IMPL(label, ante, cons)
`define BVIR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/bvir_pkg.sv]
// Package with payload types, operation codes and status codes of the vector core.
package bvir_pkg;

  localparam int unsigned DefDepth = 64;

  localparam logic [2:0] FuncAppend    = 3'd0;
  localparam logic [2:0] FuncPopBack   = 3'd1;
  localparam logic [2:0] FuncRemFront  = 3'd2;
  localparam logic [2:0] FuncPushFront = 3'd3;
  localparam logic [2:0] FuncInsert    = 3'd4;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusEmpty  = 2'd2;
  localparam logic [1:0] StatusBadIdx = 2'd3;

  typedef enum logic [1:0] {
    OpHold,
    OpInsert,
    OpPop,
    OpRemFront
  } bvir_op_e;

  typedef struct packed {
    bvir_op_e    op;
    logic [31:0] word;
  } bvir_cmd_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] word_in;
  } bvir_in_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic [1:0]         status;
    logic [6:0]         fill_after;
  } bvir_out_t;

endpackage

[rtl/bvir_cell.sv]
// One storage cell of the vector row: holds one slot and trades words with its neighbors.
module bvir_cell import bvir_pkg::*; #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bvir_cmd_t       cmd_i,
  input  logic [IdxW-1:0] pos_i,
  input  logic [IdxW-1:0] last_i,
  input  logic [31:0]     left_i,
  input  logic [31:0]     right_i,
  output logic [31:0]     slot_o,
  output logic [31:0]     rd_o
);

  localparam logic [IdxW-1:0] Idx = IdxW'(Index);

  logic [31:0] slot_d, slot_q;

  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      OpInsert: begin
        if (Idx == pos_i) begin
          slot_d = cmd_i.word;
        end else if (Idx > pos_i) begin
          slot_d = left_i;
        end
      end
      OpRemFront: begin
        slot_d = right_i;
      end
      OpPop: begin
        if (Idx == last_i) begin
          slot_d = '0;
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
  assign rd_o   = (Idx == last_i) ? slot_q : '0;

endmodule

[rtl/bvir_out_buf.sv]
// Two-entry output buffer: result register plus skid register.
module bvir_out_buf import bvir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bvir_out_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bvir_out_t out_data_o
);

  logic      out_valid_d, out_valid_q;
  logic      skid_valid_d, skid_valid_q;
  bvir_out_t out_data_d, out_data_q;
  bvir_out_t skid_data_d, skid_data_q;
  logic      fire;

  assign in_ready_o = !skid_valid_q;
  assign fire       = in_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = fire;
        out_data_d  = in_data_i;
      end
    end else if (fire) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/bounded_vector_insert_remove_core.sv]
// A result is registered in the output buffer's result register, or in its skid
// register while that is held. Throughput: one transaction per cycle unless stalled;
// all cells of the row shift in the same cycle. Output side holds a result register
// and a skid register, so input stalls only when both are full.
// Reset clears every cell to zero and the fill count to zero; no clearing pass.
// Top level of the bounded vector insert/remove core.
`include "bounded_vector_insert_remove_core_assert.svh"

module bounded_vector_insert_remove_core import bvir_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bvir_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bvir_out_t out_data_o
);

  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [FillW-1:0] fill_d, fill_q;
  logic [FillW-1:0] pos_w, last_w;
  logic [31:0]      pos_ext, fill_ext, fill_d_ext;
  logic [31:0]      slot_w [Depth];
  logic [31:0]      rd_w [Depth];
  logic [31:0]      left_w [Depth];
  logic [31:0]      right_w [Depth];
  logic [31:0]      rd_any;
  logic             in_fire, grow, grow_ok, full, empty, buf_ready;
  bvir_cmd_t        cmd;
  bvir_out_t        res;

  assign in_ready_o = buf_ready;
  assign in_fire    = in_valid_i && buf_ready;

  assign full     = (fill_q == FillW'(Depth));
  assign empty    = (fill_q == '0);
  assign last_w   = fill_q - 1'b1;
  assign pos_ext  = 32'(in_data_i.position);
  assign fill_ext = 32'(fill_q);
  assign grow     = (in_data_i.func == FuncAppend) || (in_data_i.func == FuncPushFront) ||
                    (in_data_i.func == FuncInsert);
  assign grow_ok  = in_fire && grow && (res.status == StatusOk);

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < Depth; i++) begin
      rd_any = rd_any | rd_w[i];
    end
  end

  always_comb begin
    cmd.op       = OpHold;
    cmd.word     = in_data_i.word_in;
    pos_w        = fill_q;
    fill_d       = fill_q;
    res.word_out = '0;
    res.status   = StatusOk;
    case (in_data_i.func)
      FuncAppend, FuncPushFront, FuncInsert: begin
        if (full) begin
          res.status = StatusFull;
        end else if (in_data_i.func == FuncInsert && pos_ext > fill_ext) begin
          res.status = StatusBadIdx;
        end else begin
          cmd.op = OpInsert;
          fill_d = fill_q + 1'b1;
          if (in_data_i.func == FuncPushFront) begin
            pos_w = '0;
          end else if (in_data_i.func == FuncInsert) begin
            pos_w = pos_ext[FillW-1:0];
          end
        end
      end
      FuncPopBack: begin
        if (empty) begin
          res.status = StatusEmpty;
        end else begin
          cmd.op       = OpPop;
          fill_d       = last_w;
          res.word_out = rd_any;
        end
      end
      FuncRemFront: begin
        if (empty) begin
          res.status = StatusEmpty;
        end else begin
          cmd.op = OpRemFront;
          fill_d = last_w;
        end
      end
      default: begin
        cmd.op = OpHold;
      end
    endcase
    if (!in_fire) begin
      cmd.op = OpHold;
      fill_d = fill_q;
    end
  end

  assign fill_d_ext     = 32'(fill_d);
  assign res.fill_after = fill_d_ext[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_mid_l
      assign left_w[g] = slot_w[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_mid_r
      assign right_w[g] = slot_w[g+1];
    end

    bvir_cell #(
      .Index (g),
      .IdxW  (FillW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (pos_w),
      .last_i  (last_w),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .slot_o  (slot_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  bvir_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `BVIR_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FillW'(Depth))
  `BVIR_ASSERT_NEXT(a_grow_incr, grow_ok, fill_q == $past(fill_q) + 1'b1)
  `BVIR_ASSERT_NEXT(a_refused_hold, in_fire && res.status != StatusOk, $stable(fill_q))
  `BVIR_ASSERT_IMPL(a_top_slot_zero, slot_w[Depth-1] != '0, full)

endmodule

[dv/bounded_vector_insert_remove_core_tb.sv]
// Self-checking testbench for the bounded vector insert/remove core.
`timescale 1ns / 1ps

module bounded_vector_insert_remove_core_tb;
  import bvir_pkg::*;

  localparam int unsigned Depth         = DefDepth;
  localparam int unsigned NumFuncCodes  = 8;
  localparam int unsigned MaxPosition   = 127;
  localparam int unsigned ClkPeriodNs   = 20;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned IdlePct       = 20;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned TimeoutNs     = 4_000_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  bvir_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  bvir_out_t out_data_o;

  logic signed [31:0] vec_mem [Depth] = '{default: '0};
  int unsigned        vec_fill        = 0;
  int unsigned        deepest_fill    = 0;
  int unsigned        status_seen [4] = '{default: 0};
  int unsigned        requests_sent   = 0;
  int unsigned        mismatches      = 0;
  bvir_out_t          pending_replies [$];

  bit          steady_flow   = 1'b0;
  bit          hold_off_req  = 1'b0;
  int unsigned hold_off_left = 0;

  bounded_vector_insert_remove_core #(
    .Depth(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #(ClkPeriodNs / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bvir_out_t apply_request(bvir_in_t req);
    bvir_out_t   rsp;
    int unsigned slot;
    rsp = '0;
    rsp.status = StatusOk;
    case (req.func)
      FuncAppend, FuncPushFront, FuncInsert: begin
        if (vec_fill >= Depth) begin
          rsp.status = StatusFull;
        end else if (req.func == FuncInsert && req.position > vec_fill) begin
          rsp.status = StatusBadIdx;
        end else begin
          if (req.func == FuncAppend) slot = vec_fill;
          else if (req.func == FuncPushFront) slot = 0;
          else slot = req.position;
          for (int unsigned i = vec_fill; i > slot; i--) vec_mem[i] = vec_mem[i - 1];
          vec_mem[slot] = req.word_in;
          vec_fill++;
        end
      end
      FuncPopBack: begin
        if (vec_fill == 0) begin
          rsp.status = StatusEmpty;
        end else begin
          vec_fill--;
          rsp.word_out = vec_mem[vec_fill];
          vec_mem[vec_fill] = '0;
        end
      end
      FuncRemFront: begin
        if (vec_fill == 0) begin
          rsp.status = StatusEmpty;
        end else begin
          for (int unsigned i = 0; i + 1 < vec_fill; i++) vec_mem[i] = vec_mem[i + 1];
          vec_fill--;
          vec_mem[vec_fill] = '0;
        end
      end
      default: ;
    endcase
    rsp.fill_after = vec_fill[6:0];
    status_seen[rsp.status]++;
    if (vec_fill > deepest_fill) deepest_fill = vec_fill;
    return rsp;
  endfunction

  function automatic logic signed [31:0] random_word();
    if ($urandom_range(0, 7) != 0) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic bvir_in_t random_request(int unsigned grow_pct);
    bvir_in_t req;
    req.word_in  = random_word();
    req.position = 7'($urandom_range(0, MaxPosition));
    if ($urandom_range(0, 99) < 4) begin
      req.func = 3'($urandom_range(FuncInsert + 1, NumFuncCodes - 1));
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       req.func = FuncAppend;
        1:       req.func = FuncPushFront;
        default: req.func = FuncInsert;
      endcase
      if (req.func == FuncInsert && $urandom_range(0, 9) < 8) begin
        req.position = 7'($urandom_range(0, vec_fill));
      end else if (req.func == FuncInsert && $urandom_range(0, 1) == 0) begin
        req.position = 7'($urandom_range(vec_fill + 1, MaxPosition));
      end
    end else begin
      req.func = $urandom_range(0, 1) ? FuncPopBack : FuncRemFront;
    end
    return req;
  endfunction

  task automatic issue_request(input logic [2:0] func, input int unsigned position,
                               input logic signed [31:0] word);
    int unsigned gap;
    bvir_in_t    req;
    req.func     = func;
    req.position = 7'(position);
    req.word_in  = word;
    gap = (!steady_flow && $urandom_range(0, 99) < IdlePct) ? $urandom_range(1, 2) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_replies.push_back(apply_request(req));
    requests_sent++;
  endtask

  task automatic issue_random(input int unsigned grow_pct);
    bvir_in_t req;
    req = random_request(grow_pct);
    issue_request(req.func, req.position, req.word_in);
  endtask

  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HoldOffCycles;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else if (steady_flow) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    bvir_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transaction, got word_out %0d status %0d fill_after %0d",
                 $time, out_data_o.word_out, out_data_o.status, out_data_o.fill_after);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data_o.word_out !== want.word_out) begin
          $display("%0t: word_out mismatch, expected %0d, got %0d",
                   $time, want.word_out, out_data_o.word_out);
          mismatches++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.fill_after !== want.fill_after) begin
          $display("%0t: fill_after mismatch, expected %0d, got %0d",
                   $time, want.fill_after, out_data_o.fill_after);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_store();
    issue_request(FuncPopBack, 0, 32'sd5);
    issue_request(FuncRemFront, MaxPosition, -32'sd5);
    issue_request(FuncInsert, 1, 32'sd7);
    issue_request(FuncInsert, MaxPosition, 32'sh7fff_ffff);
    for (int unsigned f = FuncInsert + 1; f < NumFuncCodes; f++) begin
      issue_request(3'(f), $urandom_range(0, MaxPosition), random_word());
    end
  endtask

  task automatic test_each_operation();
    issue_request(FuncAppend, MaxPosition, 32'sh7fff_ffff);
    issue_request(FuncPushFront, 0, 32'sh8000_0000);
    issue_request(FuncInsert, 2, 32'sh0);
    issue_request(FuncInsert, 1, -32'sd1);
    issue_request(FuncInsert, 0, random_word());
    issue_request(FuncInsert, 6, random_word());
    issue_request(FuncInsert, 4, random_word());
    issue_request(FuncPopBack, 0, random_word());
    issue_request(FuncRemFront, 0, random_word());
    issue_request(FuncRemFront, 0, random_word());
    while (vec_fill != 0) issue_request(FuncPopBack, 0, random_word());
  endtask

  task automatic test_fill_to_capacity();
    while (vec_fill < Depth) issue_random(100);
    issue_request(FuncAppend, 0, random_word());
    issue_request(FuncPushFront, 0, random_word());
    issue_request(FuncInsert, MaxPosition, random_word());
    issue_request(FuncInsert, Depth, random_word());
    issue_request(FuncInsert, 0, random_word());
    while (vec_fill != 0) issue_random(0);
    issue_request(FuncRemFront, 0, random_word());
  endtask

  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    repeat (40) issue_random(60);
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (60) issue_random(50);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_mix();
    repeat (50) issue_random(75);
    repeat (50) issue_random(25);
    repeat (50) issue_random(55);
    repeat (50) issue_random(85);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_each_operation();
    test_fill_to_capacity();
    test_output_backpressure();
    test_back_to_back();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d requests, deepest fill %0d of %0d.", requests_sent, deepest_fill, Depth);
    $display("Status counts: ok %0d, full %0d, empty %0d, bad index %0d.",
             status_seen[StatusOk], status_seen[StatusFull], status_seen[StatusEmpty],
             status_seen[StatusBadIdx]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
